>>> hw/rtl/ecs_pkg.sv
// ecs_pkg: types, byte codes and the opening prefix table for the escape channel splitter
// no dependencies; imported by ecs_classify and escape_channel_splitter_unit
package ecs_pkg;

	localparam int unsigned OPEN_LEN = 7;

	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ETX    = 8'h03;
	localparam logic [7:0] CH_EOT    = 8'h04;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [1:0] KIND_CONSOLE = 2'd0;
	localparam logic [1:0] KIND_CMD     = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;
	localparam logic [1:0] KIND_ABANDON = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MATCH,
		PH_TEXT
	} phase_t;

	typedef enum logic {
		SQ_READY,
		SQ_REPLAY
	} sq_state_t;

	typedef struct packed {
		logic opener;
		logic dollar;
		logic prefix_hit;
		logic terminator;
		logic abandon;
	} cls_t;

	function automatic logic [7:0] open_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = CH_ESC;
			3'd1:    b = 8'h5d;
			3'd2:    b = 8'h56;
			3'd3:    b = 8'h50;
			3'd4:    b = 8'h44;
			3'd5:    b = 8'h50;
			3'd6:    b = 8'h3b;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

>>> hw/rtl/ecs_classify.sv
// ecs_classify: sorts one request byte against the prefix position and the control codes
// depends on ecs_pkg
module ecs_classify
	import ecs_pkg::*;
(
	input  logic [7:0] byte_in,
	input  logic [2:0] pos,
	output cls_t       cls
);

	logic is_ctrl;
	logic is_allowed;

	always_comb begin
		is_ctrl    = byte_in < CH_SPACE;
		is_allowed = (byte_in == CH_CR) || (byte_in == CH_LF) ||
			(byte_in == CH_BEL) || (byte_in == CH_TAB);
		cls.dollar     = byte_in == CH_DOLLAR;
		cls.opener     = (byte_in == CH_ESC) || (byte_in == CH_DOLLAR);
		cls.prefix_hit = (pos >= 3'd1) && (pos < 3'(OPEN_LEN)) && (byte_in == open_byte(pos));
		cls.terminator = (byte_in == CH_ETX) || (byte_in == CH_EOT);
		cls.abandon    = is_ctrl && !is_allowed && !cls.terminator;
	end

endmodule

>>> hw/rtl/escape_channel_splitter_unit.sv
// escape_channel_splitter_unit: top level, splits console bytes from an in-band command channel
// depends on ecs_pkg and ecs_classify
// a single result is registered and shown in the cycle after its request is accepted
// throughput: one request per cycle for console, cmd, done and prefix bytes unless output stalls
// a prefix mismatch at position p replays p+1 results, one per cycle unless stalled, the first
// via sequencer and output registers; an abandon gives two results; input is stalled meanwhile
// reset: arst_n clears phase, prefix position, dollar flag, count, sequencer and output valid
module escape_channel_splitter_unit
	import ecs_pkg::*;
#(
	parameter int unsigned CMD_MAX = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data,
	output logic [8:0] cmd_length,
	output logic       last
);

	localparam int unsigned KW = $clog2(CMD_MAX + 1);

	phase_t     phase_q, phase_d;
	logic [2:0] pos_q, pos_d;
	logic       dollar_q, dollar_d;
	logic [KW-1:0] kept_q, kept_d;

	sq_state_t  sq_q, sq_d;
	logic [2:0] idx_q, end_q;
	logic [7:0] byte_q;
	logic       rep_dollar_q;

	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic [8:0] len_q;
	logic       last_q;

	cls_t       cls;
	logic       out_free, accept, emit;

	logic       ld_out, ld_last, start_seq, start_dollar;
	logic [1:0] ld_kind;
	logic [7:0] ld_data;
	logic [8:0] ld_len;
	logic [2:0] seq_idx, seq_end;
	logic [KW+8:0] kept_ext;

	logic [7:0] seq_data;
	logic       seq_last;

	ecs_classify u_classify (
		.byte_in (byte_in),
		.pos     (pos_q),
		.cls     (cls)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;
	assign kept_ext = {9'd0, kept_q};

	// sequencer next state
	always_comb begin
		sq_d = sq_q;
		unique case (sq_q)
			SQ_READY: begin
				if (accept && start_seq)
					sq_d = SQ_REPLAY;
			end
			SQ_REPLAY: begin
				if (out_free && (idx_q == end_q))
					sq_d = SQ_READY;
			end
			default: sq_d = SQ_READY;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		emit     = 1'b0;
		unique case (sq_q)
			SQ_READY:  in_stall = !out_free;
			SQ_REPLAY: emit = out_free;
			default:   in_stall = 1'b1;
		endcase
	end

	// replayed byte at the current index
	always_comb begin
		seq_last = idx_q == end_q;
		if (seq_last)
			seq_data = byte_q;
		else if (idx_q == 3'd0)
			seq_data = rep_dollar_q ? CH_DOLLAR : CH_ESC;
		else
			seq_data = open_byte(idx_q);
	end

	// per-request decode
	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		dollar_d     = dollar_q;
		kept_d       = kept_q;
		ld_out       = 1'b0;
		ld_kind      = KIND_CONSOLE;
		ld_data      = byte_in;
		ld_len       = 9'd0;
		ld_last      = 1'b1;
		start_seq    = 1'b0;
		start_dollar = dollar_q;
		seq_idx      = 3'd0;
		seq_end      = 3'd0;
		unique case (phase_q)
			PH_MATCH: begin
				if (cls.prefix_hit) begin
					pos_d = pos_q + 3'd1;
					if (pos_q == 3'(OPEN_LEN - 1)) begin
						phase_d = PH_TEXT;
						kept_d  = '0;
					end
				end else begin
					start_seq = 1'b1;
					seq_idx   = 3'd0;
					seq_end   = pos_q;
					phase_d   = PH_IDLE;
					pos_d     = 3'd0;
					dollar_d  = 1'b0;
					kept_d    = '0;
				end
			end
			PH_TEXT: begin
				if (cls.terminator) begin
					ld_out   = 1'b1;
					ld_kind  = KIND_DONE;
					ld_data  = 8'd0;
					ld_len   = kept_ext[8:0];
					phase_d  = PH_IDLE;
					pos_d    = 3'd0;
					dollar_d = 1'b0;
					kept_d   = '0;
				end else if (cls.abandon) begin
					ld_out    = 1'b1;
					ld_kind   = KIND_ABANDON;
					ld_data   = 8'd0;
					ld_last   = 1'b0;
					start_seq = 1'b1;
					seq_idx   = 3'd1;
					seq_end   = 3'd1;
					phase_d   = PH_IDLE;
					pos_d     = 3'd0;
					dollar_d  = 1'b0;
					kept_d    = '0;
				end else if (kept_q < KW'(CMD_MAX)) begin
					ld_out  = 1'b1;
					ld_kind = KIND_CMD;
					kept_d  = kept_q + KW'(1);
				end
			end
			default: begin
				if (cls.opener) begin
					phase_d  = PH_MATCH;
					pos_d    = 3'd1;
					dollar_d = cls.dollar;
				end else begin
					ld_out = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= 3'd0;
			dollar_q <= 1'b0;
			kept_q   <= '0;
			sq_q     <= SQ_READY;
			idx_q    <= 3'd0;
			end_q    <= 3'd0;
		end else begin
			sq_q <= sq_d;
			if (accept) begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				dollar_q <= dollar_d;
				kept_q   <= kept_d;
				if (start_seq) begin
					idx_q <= seq_idx;
					end_q <= seq_end;
				end
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && start_seq) begin
			byte_q       <= byte_in;
			rep_dollar_q <= start_dollar;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (accept && ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= KIND_CONSOLE;
			data_q <= seq_data;
			len_q  <= 9'd0;
			last_q <= seq_last;
		end else if (accept && ld_out) begin
			kind_q <= ld_kind;
			data_q <= ld_data;
			len_q  <= ld_len;
			last_q <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign data       = data_q;
	assign cmd_length = len_q;
	assign last       = last_q;

	a_text_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TEXT) |-> (pos_q == 3'(OPEN_LEN)))
		else $error("text phase without full prefix");

	a_kept_max: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= KW'(CMD_MAX))
		else $error("command count beyond maximum");

	a_replay_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_q == SQ_REPLAY) |-> (idx_q <= end_q))
		else $error("replay index past its end");

	a_mismatch_replay: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (phase_q == PH_MATCH) && !cls.prefix_hit) |=>
			((sq_q == SQ_REPLAY) && (idx_q == 3'd0)))
		else $error("prefix mismatch did not start a replay");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == KIND_DONE || kind_q == KIND_CMD)) |-> last_q)
		else $error("single result not marked last");

endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for escape_channel_splitter_unit, predicts console, command,
// done and abandon results per request and checks them in order under mixed idle and stall
// depends on ecs_pkg and escape_channel_splitter_unit
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ecs_pkg::*;

	localparam int unsigned CMD_MAX = 256;
	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 12;
	localparam int TIMEOUT_NS = 10_000_000;
	localparam logic [7:0] OPENER [0:6] = '{CH_ESC, 8'h5d, 8'h56, 8'h50, 8'h44, 8'h50, 8'h3b};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [8:0] len;
		logic       last;
	} split_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] byte_in;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] kind;
	logic [7:0] data;
	logic [8:0] cmd_length;
	logic       last;

	split_result_t expected_splits[$];

	phase_t     sp_phase;
	logic [2:0] sp_pos;
	logic       sp_from_dollar;
	int         sp_kept;

	int idle_pct;
	int stall_pct;
	int hold_asked;
	int hold_seen;
	int hold_left;
	int requests_sent;
	int results_checked;
	int input_held_cycles;
	int mismatches;
	int failures;

	escape_channel_splitter_unit #(.CMD_MAX(CMD_MAX)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_in    (byte_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data       (data),
		.cmd_length (cmd_length),
		.last       (last)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void expect_result(logic [1:0] k, logic [7:0] d, logic [8:0] n);
		split_result_t r;
		r.kind = k;
		r.data = d;
		r.len = n;
		r.last = 1'b0;
		expected_splits.push_back(r);
	endfunction

	function automatic void reset_splitter_state();
		sp_phase = PH_IDLE;
		sp_pos = 3'd0;
		sp_from_dollar = 1'b0;
		sp_kept = 0;
	endfunction

	function automatic void predict_split(logic [7:0] b);
		int start;
		split_result_t r;
		start = expected_splits.size();
		if (sp_phase == PH_MATCH) begin
			if (sp_pos >= 1 && sp_pos < OPEN_LEN && b == OPENER[sp_pos]) begin
				sp_pos = sp_pos + 3'd1;
				if (sp_pos == OPEN_LEN) begin
					sp_phase = PH_TEXT;
					sp_kept = 0;
				end
				return;
			end
			expect_result(KIND_CONSOLE, sp_from_dollar ? CH_DOLLAR : CH_ESC, 9'd0);
			for (int i = 1; i < sp_pos; i++)
				expect_result(KIND_CONSOLE, OPENER[i], 9'd0);
			expect_result(KIND_CONSOLE, b, 9'd0);
			reset_splitter_state();
		end else if (sp_phase == PH_TEXT) begin
			if (b == CH_ETX || b == CH_EOT) begin
				expect_result(KIND_DONE, 8'd0, sp_kept[8:0]);
				reset_splitter_state();
			end else if (b < CH_SPACE && b != CH_CR && b != CH_LF && b != CH_BEL
					&& b != CH_TAB) begin
				expect_result(KIND_ABANDON, 8'd0, 9'd0);
				expect_result(KIND_CONSOLE, b, 9'd0);
				reset_splitter_state();
			end else if (sp_kept < CMD_MAX) begin
				sp_kept++;
				expect_result(KIND_CMD, b, 9'd0);
			end
		end else begin
			if (b == CH_ESC || b == CH_DOLLAR) begin
				sp_phase = PH_MATCH;
				sp_pos = 3'd1;
				sp_from_dollar = (b == CH_DOLLAR);
			end else begin
				expect_result(KIND_CONSOLE, b, 9'd0);
			end
		end
		if (expected_splits.size() > start) begin
			r = expected_splits.pop_back();
			r.last = 1'b1;
			expected_splits.push_back(r);
		end
	endfunction

	function automatic logic [7:0] random_text_byte();
		logic [7:0] b;
		if ($urandom_range(99) < 85) begin
			b = 8'($urandom_range(8'hff, CH_SPACE));
		end else begin
			case ($urandom_range(3))
				0: b = CH_CR;
				1: b = CH_LF;
				2: b = CH_BEL;
				default: b = CH_TAB;
			endcase
		end
		return b;
	endfunction

	function automatic logic [7:0] random_abandon_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(CH_SPACE - 1));
		while (b == CH_ETX || b == CH_EOT || b == CH_CR || b == CH_LF || b == CH_BEL
				|| b == CH_TAB);
		return b;
	endfunction

	// entered and left at a falling edge
	task automatic send_request(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			byte_in <= 8'($urandom_range(255));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		do
			@(posedge clk);
		while (in_stall);
		predict_split(b);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_splits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_command(input logic [7:0] opener, input int n_text,
			input logic [7:0] ending);
		send_request(opener);
		for (int i = 1; i < OPEN_LEN; i++)
			send_request(OPENER[i]);
		for (int i = 0; i < n_text; i++)
			send_request(random_text_byte());
		send_request(ending);
	endtask

	task automatic test_directed();
		logic [7:0] seq [0:26];
		seq = '{8'h00, 8'hff, 8'h41,
			CH_ESC, 8'h5d, 8'h56, 8'h50, 8'h44, 8'h50, 8'h3b,
			CH_TAB, CH_LF, CH_CR, CH_BEL, CH_SPACE, 8'hff, CH_EOT,
			CH_DOLLAR, 8'h5d, 8'h56, 8'h50, 8'h44, 8'h50, 8'h58,
			CH_DOLLAR, CH_ESC, CH_ESC};
		idle_pct = 0;
		stall_pct = 0;
		foreach (seq[i])
			send_request(seq[i]);
		// opener followed by the other opener replays both as console bytes
		send_request(CH_DOLLAR);
		wait_idle();
	endtask

	task automatic test_output_hold();
		idle_pct = 0;
		stall_pct = 0;
		hold_asked++;
		for (int r = 0; r < 3; r++) begin
			send_request(CH_DOLLAR);
			for (int i = 1; i < OPEN_LEN - 1; i++)
				send_request(OPENER[i]);
			send_request(8'($urandom_range(8'h3a, 8'h30)));
			for (int i = 0; i < 5; i++)
				send_request(8'($urandom_range(8'h7e, 8'h41)));
		end
		wait_idle();
	endtask

	task automatic test_command_overflow();
		idle_pct = 23;
		stall_pct = 23;
		send_command(CH_ESC, CMD_MAX + 8, CH_ETX);
		wait_idle();
	endtask

	task automatic test_random_stream(input int n_items, input int idle, input int stall);
		int sent;
		int brk;
		int n_text;
		logic [7:0] b;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 70) begin
				b = $urandom_range(1) ? CH_ESC : CH_DOLLAR;
				brk = ($urandom_range(99) < 25) ? $urandom_range(6, 1) : OPEN_LEN;
				if (brk < OPEN_LEN) begin
					send_request(b);
					for (int i = 1; i < brk; i++)
						send_request(OPENER[i]);
					b = 8'($urandom_range(255));
					if (b == OPENER[brk])
						b = ~b;
					send_request(b);
					sent += brk + 1;
				end else begin
					n_text = ($urandom_range(9) == 0) ? $urandom_range(30, 13)
						: $urandom_range(12);
					case ($urandom_range(3))
						0: b = CH_ETX;
						1: b = CH_EOT;
						2: b = random_abandon_byte();
						default: b = $urandom_range(1) ? CH_ETX : random_abandon_byte();
					endcase
					send_command($urandom_range(1) ? CH_ESC : CH_DOLLAR, n_text, b);
					sent += OPEN_LEN + n_text + 1;
				end
			end else begin
				send_request(8'($urandom_range(255)));
				sent++;
			end
		end
		wait_idle();
	endtask

	// receiver stall, with a long hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_stall)
			input_held_cycles++;
	end

	always @(posedge clk) begin : check_results
		split_result_t got;
		split_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind;
			got.data = data;
			got.len = cmd_length;
			got.last = last;
			results_checked++;
			if (expected_splits.size() == 0) begin
				failures++;
				if (mismatches < 10)
					$display("unexpected result: kind %0d data %02h length %0d last %0d",
						got.kind, got.data, got.len, got.last);
				mismatches++;
			end else begin
				want = expected_splits.pop_front();
				if (got.kind !== want.kind || got.data !== want.data
						|| got.len !== want.len || got.last !== want.last) begin
					failures++;
					if (mismatches < 10)
						$display({"mismatch at %0t: expected kind %0d data %02h ",
							"length %0d last %0d, got kind %0d data %02h ",
							"length %0d last %0d"},
							$realtime, want.kind, want.data, want.len, want.last,
							got.kind, got.data, got.len, got.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#TIMEOUT_NS;
		$display("timeout with %0d results outstanding", expected_splits.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = 8'h00;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_asked = 0;
		hold_seen = 0;
		hold_left = 0;
		requests_sent = 0;
		results_checked = 0;
		input_held_cycles = 0;
		mismatches = 0;
		failures = 0;
		reset_splitter_state();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_output_hold();
		test_command_overflow();
		test_random_stream(32, 0, 0);
		test_random_stream(32, 87, 0);
		test_random_stream(32, 0, 87);
		test_random_stream(32, 23, 23);

		failures += expected_splits.size();
		$display("%0d requests sent, %0d results checked, %0d mismatches, input held %0d cycles",
			requests_sent, results_checked, mismatches, input_held_cycles);
		$display("covered prefix replays, done and abandoned commands, a full command and a long output hold");
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
